// ===== rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger: configuration
// reset values, register indexes, the control word and distance scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_TRIGGER_HIGH = 2'd0;
    localparam logic [1:0] REG_WAIT_LIMIT   = 2'd1;
    localparam logic [1:0] REG_MAX_ECHO     = 2'd2;
    localparam logic [1:0] REG_ECHO_POL     = 2'd3;

    localparam logic [7:0]  RST_TRIGGER_HIGH = 8'd10;
    localparam logic [15:0] RST_WAIT_LIMIT   = 16'd5000;
    localparam logic [15:0] RST_MAX_ECHO     = 16'd5800;
    localparam logic        RST_ECHO_POL     = 1'b1;

    localparam logic [7:0] TRIG_LOW_TICKS = 8'd2;

    // distance = (width*256 + 29) / 58, as a multiply by ceil(2^30 / 58)
    localparam logic [23:0] DIST_ROUND   = 24'd29;
    localparam logic [24:0] DIST_RECIP   = 25'd18512791;
    localparam int          DIST_SHIFT   = 30;

    typedef struct packed {
        logic [7:0]  trigger_high_ticks;
        logic [15:0] wait_limit;
        logic [15:0] max_echo_ticks;
        logic        echo_active_high;
    } uer_cfg_t;

    typedef struct packed {
        logic        trig;
        logic        busy;
        logic        done;
        logic        tout;
        logic        dist_en;
        logic [15:0] width;
    } uer_item_t;

endpackage

`default_nettype wire

// ===== rtl/uer_regs.sv =====
// ----------------------------------------------------------------------------
// uer_regs
// APB-style configuration registers of the echo ranger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uer_regs
    import uer_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output uer_cfg_t                   cfg
);

    uer_cfg_t   cfg_reg;
    uer_cfg_t   cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TRIGGER_HIGH: cfg_next.trigger_high_ticks = pwdata[7:0];
                REG_WAIT_LIMIT:   cfg_next.wait_limit         = pwdata[15:0];
                REG_MAX_ECHO:     cfg_next.max_echo_ticks     = pwdata[15:0];
                REG_ECHO_POL:     cfg_next.echo_active_high   = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TRIGGER_HIGH: prdata = {24'd0, cfg_reg.trigger_high_ticks};
            REG_WAIT_LIMIT:   prdata = {16'd0, cfg_reg.wait_limit};
            REG_MAX_ECHO:     prdata = {16'd0, cfg_reg.max_echo_ticks};
            REG_ECHO_POL:     prdata = {31'd0, cfg_reg.echo_active_high};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_high_ticks <= RST_TRIGGER_HIGH;
            cfg_reg.wait_limit         <= RST_WAIT_LIMIT;
            cfg_reg.max_echo_ticks     <= RST_MAX_ECHO;
            cfg_reg.echo_active_high   <= RST_ECHO_POL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uer_ctrl.sv =====
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: trigger timing, echo wait and pulse width count.
// Updates its state on each accepted word and registers the control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uer_ctrl
    import uer_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  uer_cfg_t       cfg,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      command,
    input  wire logic      echo_level,
    output logic           item_valid,
    input  wire logic      item_ready,
    output uer_item_t      item
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
    localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
    localparam logic [2:0] PH_WAIT_END  = 3'd3;
    localparam logic [2:0] PH_WAIT_RISE = 3'd4;
    localparam logic [2:0] PH_MEASURE   = 3'd5;

    logic [2:0]  phase_reg,       phase_next;
    logic [7:0]  phase_ticks_reg, phase_ticks_next;
    logic [15:0] wait_count_reg,  wait_count_next;
    logic [15:0] echo_width_reg,  echo_width_next;
    logic        item_valid_reg,  item_valid_next;
    uer_item_t   item_reg,        item_next;

    logic        accept;
    logic        active;
    logic [7:0]  high_ticks;
    logic [7:0]  tick_inc;
    logic        wait_hit;
    logic [15:0] wait_inc;
    logic [16:0] width_inc;
    logic        too_long;
    logic        done;
    logic        tout;

    assign in_ready   = !item_valid_reg || item_ready;
    assign accept     = in_valid && in_ready;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    assign active     = (echo_level == cfg.echo_active_high);
    assign high_ticks = (cfg.trigger_high_ticks == 8'd0) ? 8'd1 : cfg.trigger_high_ticks;
    assign tick_inc   = phase_ticks_reg + 8'd1;
    assign wait_hit   = (wait_count_reg == cfg.wait_limit);
    assign wait_inc   = wait_count_reg + 16'd1;
    assign width_inc  = {1'b0, echo_width_reg} + 17'd1;
    assign too_long   = (width_inc > {1'b0, cfg.max_echo_ticks});

    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        wait_count_next  = wait_count_reg;
        echo_width_next  = echo_width_reg;
        done             = 1'b0;
        tout             = 1'b0;
        item_next        = '0;

        if (command)
        begin
            phase_next       = PH_TRIG_LOW;
            phase_ticks_next = 8'd0;
            wait_count_next  = 16'd0;
            echo_width_next  = 16'd0;
        end
        else
        begin
            case (phase_reg)
                PH_TRIG_LOW:
                begin
                    phase_ticks_next = tick_inc;
                    if (tick_inc >= TRIG_LOW_TICKS)
                    begin
                        phase_next       = PH_TRIG_HIGH;
                        phase_ticks_next = 8'd0;
                    end
                end
                PH_TRIG_HIGH:
                begin
                    item_next.trig   = 1'b1;
                    phase_ticks_next = tick_inc;
                    if (tick_inc >= high_ticks || tick_inc == 8'd0)
                    begin
                        phase_next       = PH_WAIT_END;
                        phase_ticks_next = 8'd0;
                        wait_count_next  = 16'd0;
                    end
                end
                PH_WAIT_END, PH_WAIT_RISE:
                begin
                    if (phase_reg == PH_WAIT_END && active)
                    begin
                        if (wait_hit)
                        begin
                            done = 1'b1;
                            tout = 1'b1;
                        end
                        else
                        begin
                            wait_count_next = wait_inc;
                        end
                    end
                    else if (!active)
                    begin
                        phase_next = PH_WAIT_RISE;
                        if (wait_hit)
                        begin
                            done = 1'b1;
                            tout = 1'b1;
                        end
                        else
                        begin
                            wait_count_next = wait_inc;
                        end
                    end
                    else
                    begin
                        phase_next      = PH_MEASURE;
                        echo_width_next = 16'd1;
                    end
                end
                PH_MEASURE:
                begin
                    if (active)
                    begin
                        if (wait_hit || too_long)
                        begin
                            done = 1'b1;
                            tout = 1'b1;
                        end
                        else
                        begin
                            wait_count_next = wait_inc;
                            echo_width_next = width_inc[15:0];
                        end
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (done)
            begin
                phase_next = PH_IDLE;
            end
        end

        item_next.busy    = (phase_next != PH_IDLE);
        item_next.done    = done;
        item_next.tout    = tout;
        item_next.dist_en = done && !tout;
        item_next.width   = echo_width_reg;
    end

    always_comb
    begin
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= 8'd0;
            wait_count_reg  <= 16'd0;
            echo_width_reg  <= 16'd0;
            item_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (accept)
            begin
                phase_reg       <= phase_next;
                phase_ticks_reg <= phase_ticks_next;
                wait_count_reg  <= wait_count_next;
                echo_width_reg  <= echo_width_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && item_reg.done |-> !item_reg.busy)
        else $error("done word still reports busy");

    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && item_reg.trig |-> item_reg.busy && !item_reg.done)
        else $error("trigger driven outside a measurement");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !command && phase_reg == PH_IDLE |=> phase_reg == PH_IDLE)
        else $error("sequencer left idle without a start");
`endif

endmodule

`default_nettype wire

// ===== rtl/uer_dist.sv =====
// ----------------------------------------------------------------------------
// uer_dist
// Result stage: converts the echo width to Q8.8 centimeters with saturation
// and holds the finished word for the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uer_dist
    import uer_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    output logic        item_ready,
    input  uer_item_t   item,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic        trigger_level,
    output logic        busy_res,
    output logic        done_res,
    output logic        timed_out,
    output logic [15:0] distance_q8
);

    logic        out_valid_reg,  out_valid_next;
    logic        trig_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        tout_reg;
    logic [15:0] dist_reg;

    logic        take;
    logic [23:0] numer;
    logic [48:0] product;
    logic [18:0] quot;
    logic [15:0] dist_sat;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;

    assign numer    = {item.width, 8'd0} + DIST_ROUND;
    assign product  = {25'd0, numer} * {24'd0, DIST_RECIP};
    assign quot     = product[DIST_SHIFT+18:DIST_SHIFT];
    assign dist_sat = (quot[18:16] != 3'd0) ? 16'hFFFF : quot[15:0];

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            trig_reg <= item.trig;
            busy_reg <= item.busy;
            done_reg <= item.done;
            tout_reg <= item.tout;
            dist_reg <= item.dist_en ? dist_sat : 16'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = trig_reg;
    assign busy_res      = busy_reg;
    assign done_res      = done_reg;
    assign timed_out     = tout_reg;
    assign distance_q8   = dist_reg;

`ifndef NO_ASSERTIONS
    a_dist_only_success: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (!done_reg || tout_reg) |-> dist_reg == 16'd0)
        else $error("distance reported without a successful measurement");

    a_tout_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && tout_reg |-> done_reg)
        else $error("timeout flag without done");
`endif

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Ultrasonic ranger controller stepped once per microsecond tick word.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   command, echo_level
//   output    out_valid / out_ready trigger_level, busy_res, done_res,
//                                   timed_out, distance_q8
//   config    psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// One word accepted per cycle unless the output stalls. The sequencer state
// updates on accept; the result stage holds the width-to-distance multiply.
// Output stalls back up one stage at a time.
// Reset clears the sequencer to idle and loads the default register values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_core
    import uer_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  command,
    input  wire logic                  echo_level,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       trigger_level,
    output logic                       busy_res,
    output logic                       done_res,
    output logic                       timed_out,
    output logic [15:0]                distance_q8,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    uer_cfg_t  cfg;
    uer_item_t item;
    logic      item_valid;
    logic      item_ready;

    uer_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uer_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .echo_level (echo_level),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    uer_dist u_dist (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .trigger_level (trigger_level),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .timed_out     (timed_out),
        .distance_q8   (distance_q8)
    );

endmodule

`default_nettype wire
